FILE: hw/rtl/register_machine_interpreter_assert.svh
// assertion macros shared by the checker of the register machine interpreter
`ifndef REGISTER_MACHINE_INTERPRETER_ASSERT_SVH
`define REGISTER_MACHINE_INTERPRETER_ASSERT_SVH

// implication in the same cycle, disabled during reset
`define RMI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication into the next cycle, disabled during reset
`define RMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// implication into the next cycle, active during reset
`define RMI_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/rmi_pkg.sv
// types and constants of the register machine interpreter
`timescale 1ns / 1ps
`default_nettype none

package rmi_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_AW    = 4;

    localparam logic [15:0] OP_END   = 16'd0;
    localparam logic [15:0] OP_NOP   = 16'd1;
    localparam logic [15:0] OP_OUT   = 16'd2;
    localparam logic [15:0] OP_ADDK  = 16'd3;
    localparam logic [15:0] OP_ADDR  = 16'd4;
    localparam logic [15:0] OP_SUBK  = 16'd5;
    localparam logic [15:0] OP_SUBR  = 16'd6;
    localparam logic [15:0] OP_MULK  = 16'd7;
    localparam logic [15:0] OP_MULR  = 16'd8;
    localparam logic [15:0] OP_DIVK  = 16'd9;
    localparam logic [15:0] OP_DIVR  = 16'd10;
    localparam logic [15:0] OP_MOVK  = 16'd11;
    localparam logic [15:0] OP_MOVR  = 16'd12;
    localparam logic [15:0] OP_MOVRK = 16'd13;
    localparam logic [15:0] OP_LDK   = 16'd14;
    localparam logic [15:0] OP_LDR   = 16'd15;
    localparam logic [15:0] OP_LDRK  = 16'd16;
    localparam logic [15:0] OP_STK   = 16'd17;
    localparam logic [15:0] OP_STR   = 16'd18;
    localparam logic [15:0] OP_STRK  = 16'd19;
    localparam logic [15:0] OP_STRX  = 16'd20;
    localparam logic [15:0] OP_TEST  = 16'd21;
    localparam logic [15:0] OP_JMPK  = 16'd22;
    localparam logic [15:0] OP_JMPR  = 16'd23;
    localparam logic [15:0] OP_JZK   = 16'd24;
    localparam logic [15:0] OP_JZR   = 16'd25;
    localparam logic [15:0] OP_JNK   = 16'd26;
    localparam logic [15:0] OP_JNR   = 16'd27;
    localparam logic [15:0] OP_JPK   = 16'd28;
    localparam logic [15:0] OP_JPR   = 16'd29;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;
    localparam logic [1:0] ST_INV  = 2'd3;

    localparam logic [31:0] FLAG_ZERO = 32'd0;
    localparam logic [31:0] FLAG_NEG  = 32'd1;
    localparam logic [31:0] FLAG_POS  = 32'd2;

    localparam logic [2:0] CL_HALT  = 3'd0;
    localparam logic [2:0] CL_PLAIN = 3'd1;
    localparam logic [2:0] CL_ALU   = 3'd2;
    localparam logic [2:0] CL_JUMP  = 3'd3;
    localparam logic [2:0] CL_NOJ   = 3'd4;
    localparam logic [2:0] CL_DIV   = 3'd5;
    localparam logic [2:0] CL_LOAD  = 3'd6;
    localparam logic [2:0] CL_STORE = 3'd7;

    localparam logic [1:0] AF_LD    = 2'd0;
    localparam logic [1:0] AF_FETCH = 2'd1;
    localparam logic [1:0] AF_MRD   = 2'd2;
    localparam logic [1:0] AF_MWR   = 2'd3;

    localparam logic [4:0] DC_NONE     = 5'd0;
    localparam logic [4:0] DC_CLR      = 5'd1;
    localparam logic [4:0] DC_TAKE     = 5'd2;
    localparam logic [4:0] DC_MOD_INIT = 5'd3;
    localparam logic [4:0] DC_MOD_STEP = 5'd4;
    localparam logic [4:0] DC_MOD_END  = 5'd5;
    localparam logic [4:0] DC_LDWR     = 5'd6;
    localparam logic [4:0] DC_FETCH    = 5'd7;
    localparam logic [4:0] DC_REGRD    = 5'd8;
    localparam logic [4:0] DC_EXEC     = 5'd9;
    localparam logic [4:0] DC_DIV_INIT = 5'd10;
    localparam logic [4:0] DC_DIV_STEP = 5'd11;
    localparam logic [4:0] DC_DIV_FIX  = 5'd12;
    localparam logic [4:0] DC_MRD      = 5'd13;
    localparam logic [4:0] DC_MWR      = 5'd14;
    localparam logic [4:0] DC_WB       = 5'd15;
    localparam logic [4:0] DC_ADV      = 5'd16;
    localparam logic [4:0] DC_OUT      = 5'd17;

    typedef struct packed {
        logic [4:0] code;
        logic [5:0] step;
        logic [1:0] sel;
    } rmi_cmd_t;

    typedef struct packed {
        logic       cmd_step;
        logic       halted;
        logic [2:0] cls;
        logic       clr_done;
        logic       out_free;
    } rmi_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rmi_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rmi_ctrl.sv
// controller state machine of the register machine interpreter
`timescale 1ns / 1ps
`default_nettype none

module rmi_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire rmi_pkg::rmi_stat_t stat,
    output rmi_pkg::rmi_cmd_t       cmd
);
    import rmi_pkg::*;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_MOD_I = 5'd3;
    localparam logic [4:0] S_MOD_S = 5'd4;
    localparam logic [4:0] S_MOD_E = 5'd5;
    localparam logic [4:0] S_LDWR  = 5'd6;
    localparam logic [4:0] S_FETCH = 5'd7;
    localparam logic [4:0] S_REGRD = 5'd8;
    localparam logic [4:0] S_EXEC  = 5'd9;
    localparam logic [4:0] S_DIV_I = 5'd10;
    localparam logic [4:0] S_DIV_S = 5'd11;
    localparam logic [4:0] S_DIV_F = 5'd12;
    localparam logic [4:0] S_MRD   = 5'd13;
    localparam logic [4:0] S_MWR   = 5'd14;
    localparam logic [4:0] S_WB    = 5'd15;
    localparam logic [4:0] S_ADV   = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] after_reg, after_next;

    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        s_tready   = 1'b0;
        cmd.code   = DC_NONE;
        cmd.step   = cnt_reg;
        cmd.sel    = after_reg;
        unique case (state_reg)
            S_CLR: begin
                cmd.code = DC_CLR;
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.code   = DC_TAKE;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (!stat.cmd_step) begin
                    after_next = AF_LD;
                    state_next = S_MOD_I;
                end else if (stat.halted) begin
                    state_next = S_FIN;
                end else begin
                    after_next = AF_FETCH;
                    state_next = S_MOD_I;
                end
            end
            S_MOD_I: begin
                cmd.code   = DC_MOD_INIT;
                state_next = S_MOD_S;
            end
            S_MOD_S: begin
                cmd.code = DC_MOD_STEP;
                if (cnt_reg == 6'd1) begin
                    state_next = S_MOD_E;
                end
            end
            S_MOD_E: begin
                cmd.code = DC_MOD_END;
                unique case (after_reg)
                    AF_LD:    state_next = S_LDWR;
                    AF_FETCH: state_next = S_FETCH;
                    AF_MRD:   state_next = S_MRD;
                    default:  state_next = S_MWR;
                endcase
            end
            S_LDWR: begin
                cmd.code   = DC_LDWR;
                state_next = S_FIN;
            end
            S_FETCH: begin
                cmd.code = DC_FETCH;
                if (cnt_reg == 6'd8) begin
                    state_next = S_REGRD;
                end
            end
            S_REGRD: begin
                cmd.code = DC_REGRD;
                if (cnt_reg == 6'd4) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.code = DC_EXEC;
                unique case (stat.cls) inside
                    CL_HALT:            state_next = S_FIN;
                    CL_PLAIN, CL_NOJ:   state_next = S_ADV;
                    CL_ALU, CL_JUMP:    state_next = S_WB;
                    CL_DIV:             state_next = S_DIV_I;
                    CL_LOAD: begin
                        after_next = AF_MRD;
                        state_next = S_MOD_I;
                    end
                    default: begin
                        after_next = AF_MWR;
                        state_next = S_MOD_I;
                    end
                endcase
            end
            S_DIV_I: begin
                cmd.code   = DC_DIV_INIT;
                state_next = S_DIV_S;
            end
            S_DIV_S: begin
                cmd.code = DC_DIV_STEP;
                if (cnt_reg == 6'd31) begin
                    state_next = S_DIV_F;
                end
            end
            S_DIV_F: begin
                cmd.code   = DC_DIV_FIX;
                state_next = S_WB;
            end
            S_MRD: begin
                cmd.code = DC_MRD;
                if (cnt_reg == 6'd4) begin
                    state_next = S_WB;
                end
            end
            S_MWR: begin
                cmd.code = DC_MWR;
                if (cnt_reg == 6'd3) begin
                    state_next = S_ADV;
                end
            end
            S_WB: begin
                cmd.code   = DC_WB;
                state_next = (stat.cls == CL_JUMP) ? S_FIN : S_ADV;
            end
            S_ADV: begin
                cmd.code   = DC_ADV;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.code   = DC_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cnt_next = (state_next != state_reg) ? 6'd0 : cnt_reg + 6'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= 6'd0;
            after_reg <= AF_LD;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            after_reg <= after_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rmi_dp.sv
// datapath of the register machine interpreter: memories, registers, alu, divider
`timescale 1ns / 1ps
`default_nettype none

module rmi_dp #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [31:0]       s_tdata,
    input  wire rmi_pkg::rmi_cmd_t cmd,
    output rmi_pkg::rmi_stat_t     stat,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata
);
    import rmi_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW:0]   MEM_LIM   = (AW+1)'(MEM_BYTES);
    localparam logic [AW-1:0] MEM_LAST  = AW'(MEM_BYTES - 1);
    localparam logic [31:0]   MEM_W     = 32'(MEM_BYTES);
    localparam logic [31:0]   MOD_RECIP = 32'((64'd1 << (31 + AW)) / MEM_BYTES);

    logic              in_cmd_reg;
    logic [15:0]       in_addr_reg;
    logic [7:0]        in_byte_reg;
    logic [1:0]        halt_reg;
    logic [31:0]       ip_reg;
    logic [AW-1:0]     maddr_reg;
    logic [31:0]       mod_val_reg;
    logic [63:0]       mod_prod_reg;
    logic [AW:0]       mod_rem_reg;
    logic [63:0]       ibuf_reg;
    logic [15:0]       op_reg;
    logic [3:0]        x_reg, dest_reg;
    logic [31:0]       k_reg, a_reg, b_reg, flag_reg, r15_reg;
    logic [31:0]       res_reg, msrc_reg, wdata_reg;
    logic [31:0]       dd_reg, dq_reg, dr_reg;
    logic              dneg_reg;
    logic              chv_reg;
    logic [7:0]        chr_reg;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic [REG_COUNT-1:0] rv_reg;
    logic              rvq_reg;

    logic [AW-1:0]     maddr_inc;
    logic [AW:0]       mod_r;
    logic [32-AW:0]    mod_q;
    logic [31:0]       mod_qm, mod_diff;
    logic [31:0]       mod_src;
    logic              mem_we;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              reg_we;
    logic [REG_AW-1:0] reg_addr;
    logic [31:0]       reg_wdata, reg_rdata, reg_val;
    logic [31:0]       opnd, prod;
    logic [2:0]        cls_c;
    logic [31:0]       res_c, src_c, wd_c;
    logic [3:0]        dest_c;
    logic [1:0]        halt_c;
    logic [32:0]       div_t;
    logic              div_ge;
    logic [31:0]       flag_c;

    assign maddr_inc = (maddr_reg == MEM_LAST) ? '0 : maddr_reg + 1'b1;

    // reciprocal quotient estimate is low by at most one
    assign mod_q    = mod_prod_reg[63:31+AW];
    assign mod_qm   = {{(AW-1){1'b0}}, mod_q} * MEM_W;
    assign mod_diff = mod_val_reg - mod_qm;
    assign mod_r    = (mod_rem_reg >= MEM_LIM) ? mod_rem_reg - MEM_LIM : mod_rem_reg;

    always_comb begin
        case (cmd.sel)
            AF_LD:    mod_src = {16'd0, in_addr_reg};
            AF_FETCH: mod_src = ip_reg;
            default:  mod_src = msrc_reg;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = 8'd0;
        case (cmd.code)
            DC_CLR:  mem_we = 1'b1;
            DC_LDWR: begin
                mem_we    = 1'b1;
                mem_wdata = in_byte_reg;
            end
            DC_MWR: begin
                mem_we    = 1'b1;
                mem_wdata = wdata_reg[31:24];
            end
            default: mem_we = 1'b0;
        endcase
    end

    rmi_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (maddr_reg),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb begin
        reg_we    = 1'b0;
        reg_addr  = 4'd0;
        reg_wdata = res_reg;
        case (cmd.code)
            DC_REGRD: begin
                case (cmd.step)
                    6'd0:    reg_addr = ibuf_reg[35:32];
                    6'd1:    reg_addr = ibuf_reg[43:40];
                    6'd3:    reg_addr = 4'd15;
                    default: reg_addr = 4'd0;
                endcase
            end
            DC_WB: begin
                reg_we   = 1'b1;
                reg_addr = dest_reg;
            end
            DC_ADV: begin
                reg_we    = 1'b1;
                reg_addr  = 4'd1;
                reg_wdata = ip_reg + 32'd8;
            end
            default: reg_we = 1'b0;
        endcase
    end

    rmi_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regs (
        .aclk  (aclk),
        .we    (reg_we),
        .addr  (reg_addr),
        .wdata (reg_wdata),
        .rdata (reg_rdata)
    );

    assign reg_val = rvq_reg ? reg_rdata : 32'd0;

    // k variants of arithmetic have odd opcodes
    assign opnd = op_reg[0] ? k_reg : b_reg;
    assign prod = a_reg * opnd;

    always_comb begin
        if (a_reg == 32'd0) begin
            flag_c = FLAG_ZERO;
        end else if (a_reg[31]) begin
            flag_c = FLAG_NEG;
        end else begin
            flag_c = FLAG_POS;
        end
    end

    always_comb begin
        cls_c  = CL_HALT;
        res_c  = 32'd0;
        dest_c = x_reg;
        src_c  = 32'd0;
        wd_c   = 32'd0;
        halt_c = ST_INV;
        unique case (op_reg) inside
            OP_END:         halt_c = ST_END;
            OP_NOP, OP_OUT: cls_c = CL_PLAIN;
            OP_ADDK, OP_ADDR: begin
                cls_c = CL_ALU;
                res_c = a_reg + opnd;
            end
            OP_SUBK, OP_SUBR: begin
                cls_c = CL_ALU;
                res_c = a_reg - opnd;
            end
            OP_MULK, OP_MULR: begin
                cls_c = CL_ALU;
                res_c = prod;
            end
            OP_DIVK, OP_DIVR: begin
                if (opnd == 32'd0) begin
                    halt_c = ST_DIVZ;
                end else begin
                    cls_c = CL_DIV;
                end
            end
            OP_MOVK: begin
                cls_c = CL_ALU;
                res_c = k_reg;
            end
            OP_MOVR: begin
                cls_c = CL_ALU;
                res_c = b_reg;
            end
            OP_MOVRK: begin
                cls_c = CL_ALU;
                res_c = b_reg + k_reg;
            end
            OP_LDK: begin
                cls_c = CL_LOAD;
                src_c = k_reg;
            end
            OP_LDR: begin
                cls_c = CL_LOAD;
                src_c = b_reg;
            end
            OP_LDRK: begin
                cls_c = CL_LOAD;
                src_c = b_reg + k_reg;
            end
            OP_STK: begin
                cls_c = CL_STORE;
                src_c = a_reg;
                wd_c  = k_reg;
            end
            OP_STR: begin
                cls_c = CL_STORE;
                src_c = a_reg;
                wd_c  = b_reg;
            end
            OP_STRK: begin
                cls_c = CL_STORE;
                src_c = a_reg;
                wd_c  = b_reg + k_reg;
            end
            OP_STRX: begin
                cls_c = CL_STORE;
                src_c = a_reg + k_reg;
                wd_c  = b_reg;
            end
            OP_TEST: begin
                cls_c  = CL_ALU;
                dest_c = 4'd0;
                res_c  = flag_c;
            end
            OP_JMPK, OP_JMPR: begin
                cls_c  = CL_JUMP;
                dest_c = 4'd1;
                res_c  = op_reg[0] ? a_reg : k_reg;
            end
            OP_JZK, OP_JZR, OP_JNK, OP_JNR, OP_JPK, OP_JPR: begin
                dest_c = 4'd1;
                res_c  = op_reg[0] ? a_reg : k_reg;
                if ((op_reg[2:1] == 2'd0 && flag_reg == FLAG_ZERO) ||
                    (op_reg[2:1] == 2'd1 && flag_reg == FLAG_NEG) ||
                    (op_reg[2:1] == 2'd2 && flag_reg == FLAG_POS)) begin
                    cls_c = CL_JUMP;
                end else begin
                    cls_c = CL_NOJ;
                end
            end
            default: halt_c = ST_INV;
        endcase
    end

    assign div_t  = {dr_reg, dq_reg[31]};
    assign div_ge = div_t >= {1'b0, dd_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_reg    <= ST_RUN;
            ip_reg      <= 32'd0;
            maddr_reg   <= '0;
            m_valid_reg <= 1'b0;
            rv_reg      <= '0;
            rvq_reg     <= 1'b0;
        end else begin
            rvq_reg <= rv_reg[reg_addr];
            if (reg_we) begin
                rv_reg[reg_addr] <= 1'b1;
            end
            case (cmd.code) inside
                DC_CLR, DC_FETCH, DC_MRD, DC_MWR: begin
                    if (cmd.code == DC_CLR || cmd.code == DC_MWR ||
                        (cmd.code == DC_FETCH && cmd.step != 6'd8) ||
                        (cmd.code == DC_MRD && cmd.step != 6'd4)) begin
                        maddr_reg <= maddr_inc;
                    end
                end
                DC_MOD_END: maddr_reg <= mod_r[AW-1:0];
                DC_EXEC: begin
                    if (cls_c == CL_HALT) begin
                        halt_reg <= halt_c;
                    end
                end
                DC_WB: begin
                    if (dest_reg == 4'd1) begin
                        ip_reg <= res_reg;
                    end
                end
                DC_ADV: ip_reg <= ip_reg + 32'd8;
                default: ip_reg <= ip_reg;
            endcase
            if (cmd.code == DC_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.code)
            DC_TAKE: begin
                in_cmd_reg  <= s_tdata[0];
                in_addr_reg <= s_tdata[16:1];
                in_byte_reg <= s_tdata[24:17];
                chv_reg     <= 1'b0;
                chr_reg     <= 8'd0;
            end
            DC_MOD_INIT: mod_val_reg <= mod_src;
            DC_MOD_STEP: begin
                if (cmd.step == 6'd0) begin
                    mod_prod_reg <= {32'd0, mod_val_reg} * {32'd0, MOD_RECIP};
                end else begin
                    mod_rem_reg <= mod_diff[AW:0];
                end
            end
            DC_FETCH: begin
                if (cmd.step != 6'd0) begin
                    ibuf_reg <= {ibuf_reg[55:0], mem_rdata};
                end
            end
            DC_MRD: begin
                if (cmd.step != 6'd0) begin
                    ibuf_reg <= {ibuf_reg[55:0], mem_rdata};
                end
                if (cmd.step == 6'd4) begin
                    res_reg <= {ibuf_reg[23:0], mem_rdata};
                end
            end
            DC_REGRD: begin
                case (cmd.step)
                    6'd0: begin
                        op_reg <= ibuf_reg[63:48];
                        x_reg  <= ibuf_reg[43:40];
                        k_reg  <= ibuf_reg[31:0];
                    end
                    6'd1:    b_reg    <= reg_val;
                    6'd2:    a_reg    <= reg_val;
                    6'd3:    flag_reg <= reg_val;
                    default: r15_reg  <= reg_val;
                endcase
            end
            DC_EXEC: begin
                res_reg   <= res_c;
                dest_reg  <= dest_c;
                msrc_reg  <= src_c;
                wdata_reg <= wd_c;
                if (op_reg == OP_OUT) begin
                    chv_reg <= 1'b1;
                    chr_reg <= r15_reg[7:0];
                end
            end
            DC_DIV_INIT: begin
                dd_reg   <= opnd[31] ? 32'd0 - opnd : opnd;
                dq_reg   <= a_reg[31] ? 32'd0 - a_reg : a_reg;
                dr_reg   <= 32'd0;
                dneg_reg <= a_reg[31] ^ opnd[31];
            end
            DC_DIV_STEP: begin
                dr_reg <= div_ge ? 32'(div_t - {1'b0, dd_reg}) : div_t[31:0];
                dq_reg <= {dq_reg[30:0], div_ge};
            end
            DC_DIV_FIX: res_reg <= dneg_reg ? 32'd0 - dq_reg : dq_reg;
            DC_MWR:     wdata_reg <= {wdata_reg[23:0], 8'd0};
            DC_OUT: begin
                m_data_reg <= {5'd0, ip_reg[15:0], halt_reg, chr_reg, chv_reg};
            end
            default: dneg_reg <= dneg_reg;
        endcase
    end

    assign stat.cmd_step = in_cmd_reg;
    assign stat.halted   = halt_reg != ST_RUN;
    assign stat.cls      = cls_c;
    assign stat.clr_done = maddr_reg == MEM_LAST;
    assign stat.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/register_machine_interpreter.sv
// top level of the register machine interpreter
//
// channel  dir  tdata fields (lsb first)                              tuser/tlast
// s_       in   command[0] load_address[16:1] load_byte[24:17]        none
// m_       out  char_valid[0] char_out[8:1] run_status[10:9]          none
//                pointer_now[26:11]
//
// after reset a clearing pass writes every byte of memory before the first transfer
// is taken. instructions are fetched and words are loaded and stored a byte at a
// time through the byte-wide memory port, and a divide is worked out serially.
// one transfer is worked on at a time; a finished result waits in the output
// register while the next transfer is taken, and the next result waits for it.
`timescale 1ns / 1ps
`default_nettype none

module register_machine_interpreter #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // command, load_address, load_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // char_valid, char_out, run_status, pointer_now
);
    import rmi_pkg::*;

    rmi_cmd_t  cmd;
    rmi_stat_t stat;

    rmi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rmi_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/rmi_checker.sv
// port checker of the register machine interpreter and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "register_machine_interpreter_assert.svh"

module rmi_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    `RMI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stall")
    `RMI_ASSERT_SAME(a_char_running, m_tvalid && m_tdata[0], m_tdata[10:9] == 2'd0, "halted")
    `RMI_ASSERT_SAME(a_char_zero, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0, "stray byte")
    `RMI_ASSERT_NEXT(a_ready_hold, s_tready && !s_tvalid, s_tready, "ready dropped")
    `RMI_ASSERT_RST(a_reset_quiet, !aresetn, !m_tvalid && !s_tready, "busy after reset")

endmodule

bind register_machine_interpreter rmi_checker u_rmi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
